// ===== rtl/hdep_pkg.sv =====
// Package for the HTTP date parser: phase codes, status codes, the result
// entry passed from the parser to the epoch stage, and the name tables.
// No dependencies.
package hdep_pkg;

    typedef enum logic [15:0] {
        PH_WDAY  = 16'h0001,
        PH_WFULL = 16'h0002,
        PH_WSP   = 16'h0004,
        PH_D0    = 16'h0008,
        PH_D1    = 16'h0010,
        PH_DSEP  = 16'h0020,
        PH_MON   = 16'h0040,
        PH_MSEP  = 16'h0080,
        PH_Y0    = 16'h0100,
        PH_Y1    = 16'h0200,
        PH_Y2    = 16'h0400,
        PH_Y3    = 16'h0800,
        PH_YSEP  = 16'h1000,
        PH_TIME  = 16'h2000,
        PH_ZONE  = 16'h4000,
        PH_END   = 16'h8000
    } phase_t;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_WEEKDAY    = 4'd1;
    localparam logic [3:0] ST_WDAY_SEP   = 4'd2;
    localparam logic [3:0] ST_DAY_FMT    = 4'd3;
    localparam logic [3:0] ST_MONTH      = 4'd4;
    localparam logic [3:0] ST_MONTH_SEP  = 4'd5;
    localparam logic [3:0] ST_YEAR       = 4'd6;
    localparam logic [3:0] ST_DAY_RANGE  = 4'd7;
    localparam logic [3:0] ST_YEAR_SEP   = 4'd8;
    localparam logic [3:0] ST_TIME_FMT   = 4'd9;
    localparam logic [3:0] ST_TIME_RANGE = 4'd10;
    localparam logic [3:0] ST_ZONE       = 4'd11;
    localparam logic [3:0] ST_YEAR_RANGE = 4'd12;

    localparam logic [6:0] PIVOT_RESET = 7'd68;
    localparam int         QDEPTH      = 2;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] year_off;   // year - 1970
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } entry_t;

    function automatic logic [7:0] wday_char(input logic [2:0] i, input logic [3:0] k);
        logic [0:8][7:0] n;
        case (i)
            3'd0:    n = {"sunday", 24'h0};
            3'd1:    n = {"monday", 24'h0};
            3'd2:    n = {"tuesday", 16'h0};
            3'd3:    n = "wednesday";
            3'd4:    n = {"thursday", 8'h0};
            3'd5:    n = {"friday", 24'h0};
            3'd6:    n = {"saturday", 8'h0};
            default: n = '0;
        endcase
        return (k <= 4'd8) ? n[k] : 8'h00;
    endfunction

    function automatic logic [3:0] wday_len(input logic [2:0] i);
        case (i)
            3'd2:    return 4'd7;
            3'd3:    return 4'd9;
            3'd4:    return 4'd8;
            3'd6:    return 4'd8;
            default: return 4'd6;
        endcase
    endfunction

    function automatic logic [7:0] mon_char(input logic [3:0] i, input logic [1:0] k);
        logic [0:2][7:0] n;
        case (i)
            4'd0:    n = "jan";
            4'd1:    n = "feb";
            4'd2:    n = "mar";
            4'd3:    n = "apr";
            4'd4:    n = "may";
            4'd5:    n = "jun";
            4'd6:    n = "jul";
            4'd7:    n = "aug";
            4'd8:    n = "sep";
            4'd9:    n = "oct";
            4'd10:   n = "nov";
            4'd11:   n = "dec";
            default: n = '0;
        endcase
        return (k <= 2'd2) ? n[k] : 8'h00;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        case (m)
            4'd1:    return 5'd29;
            4'd3:    return 5'd30;
            4'd5:    return 5'd30;
            4'd8:    return 5'd30;
            4'd10:   return 5'd30;
            default: return 5'd31;
        endcase
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        case (m)
            4'd1:    return 9'd31;
            4'd2:    return 9'd59;
            4'd3:    return 9'd90;
            4'd4:    return 9'd120;
            4'd5:    return 9'd151;
            4'd6:    return 9'd181;
            4'd7:    return 9'd212;
            4'd8:    return 9'd243;
            4'd9:    return 9'd273;
            4'd10:   return 9'd304;
            4'd11:   return 9'd334;
            default: return 9'd0;
        endcase
    endfunction

endpackage

// ===== rtl/hdep_ifs.sv =====
// Channel interfaces: the byte stream into the parser and the result out.
// Depends on nothing.
interface hdep_date_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_char;
    modport source (output valid, output char_in, output last_char, input ready);
    modport sink (input valid, input char_in, input last_char, output ready);
endinterface

interface hdep_epoch_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;
    logic [3:0]  status;
    modport source (output valid, output epoch_seconds, output status, input ready);
    modport sink (input valid, input epoch_seconds, input status, output ready);
endinterface

// ===== rtl/hdep_front.sv =====
// Byte-level parser: walks the date fields and pushes one entry per string.
// Depends on hdep_pkg and hdep_ifs.
module hdep_front import hdep_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    hdep_date_if.sink    date,
    input  logic [6:0]   year_pivot,
    output logic         push_valid,
    output entry_t       push_entry,
    input  logic         push_ready
);

    typedef struct packed {
        logic [3:0]  err;
        logic [13:0] year;
    } settle_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  wpick_reg, wpick_next;
    logic [3:0]  off_reg, off_next;
    logic [6:0]  day_reg, day_next;
    logic [3:0]  mpick_reg, mpick_next;
    logic [6:0]  two_reg, two_next;
    logic [3:0]  d3_reg, d3_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  min_reg, min_next;
    logic [6:0]  sec_reg, sec_next;
    logic [3:0]  err_reg, err_next;

    logic [7:0]  c, lc;
    logic [3:0]  d;
    logic        is_dig, accept;
    logic        w_found, m_found;
    logic [2:0]  w_sel;
    logic [3:0]  m_sel;
    settle_t     s_take, s_fin;
    logic [3:0]  fin_err;
    logic [13:0] year_off_full;

    function automatic logic [6:0] widen_hi(input logic [6:0] two, input logic [6:0] pv);
        return (two <= pv) ? 7'd20 : 7'd19;
    endfunction

    function automatic settle_t settle(input logic [6:0] hi, input logic [6:0] lo,
                                       input logic [6:0] dv, input logic [3:0] mp);
        settle_t    r;
        logic [3:0] m;
        logic [4:0] lim;
        logic       leap;
        m    = (mp < 4'd12) ? mp : 4'd11;
        leap = (lo != 7'd0) ? (lo[1:0] == 2'd0) : (hi[1:0] == 2'd0);
        lim  = month_len(m);
        if (m == 4'd1 && !leap)
            lim = 5'd28;
        r.year = 14'(hi * 7'd100) + 14'(lo);
        if (dv == 7'd0 || dv > {2'b00, lim})
            r.err = ST_DAY_RANGE;
        else if (r.year < 14'd1970 || r.year > 14'd2105)
            r.err = ST_YEAR_RANGE;
        else
            r.err = ST_OK;
        return r;
    endfunction

    assign accept     = date.valid && date.ready;
    assign date.ready = push_ready;
    assign c          = date.char_in;
    assign lc         = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    assign is_dig     = (c >= "0" && c <= "9");
    assign d          = c[3:0] - 4'd0;

    // First weekday / month name at or after the current pick that shares the
    // matched prefix and has the incoming letter at this position.
    always_comb
    begin
        w_found = 1'b0;
        w_sel   = 3'd0;
        for (int i = 6; i >= 0; i--)
        begin
            if (3'(i) >= wpick_reg
                && (off_reg < 4'd1 || wday_char(3'(i), 4'd0) == wday_char(wpick_reg, 4'd0))
                && (off_reg < 4'd2 || wday_char(3'(i), 4'd1) == wday_char(wpick_reg, 4'd1))
                && wday_char(3'(i), off_reg) == lc)
            begin
                w_found = 1'b1;
                w_sel   = 3'(i);
            end
        end
        m_found = 1'b0;
        m_sel   = 4'd0;
        for (int i = 11; i >= 0; i--)
        begin
            if (4'(i) >= mpick_reg
                && (off_reg < 4'd1 || mon_char(4'(i), 2'd0) == mon_char(mpick_reg, 2'd0))
                && (off_reg < 4'd2 || mon_char(4'(i), 2'd1) == mon_char(mpick_reg, 2'd1))
                && mon_char(4'(i), off_reg[1:0]) == lc)
            begin
                m_found = 1'b1;
                m_sel   = 4'(i);
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        wpick_next = wpick_reg;
        off_next   = off_reg;
        day_next   = day_reg;
        mpick_next = mpick_reg;
        two_next   = two_reg;
        d3_next    = d3_reg;
        year_next  = year_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        err_next   = err_reg;
        s_take     = settle(widen_hi(two_reg, year_pivot), two_reg, day_reg, mpick_reg);

        if (err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_WDAY:
                begin
                    if (!w_found)
                        err_next = ST_WEEKDAY;
                    else
                    begin
                        wpick_next = w_sel;
                        off_next   = off_reg + 4'd1;
                        if (off_reg == 4'd2)
                            phase_next = PH_WFULL;
                    end
                end
                PH_WFULL:
                begin
                    if (off_reg < wday_len(wpick_reg) && wday_char(wpick_reg, off_reg) == lc)
                        off_next = off_reg + 4'd1;
                    else if (c == "," && (off_reg == 4'd3 || off_reg == wday_len(wpick_reg)))
                        phase_next = PH_WSP;
                    else
                        err_next = ST_WDAY_SEP;
                end
                PH_WSP:
                begin
                    if (c == " ")
                        phase_next = PH_D0;
                    else
                        err_next = ST_WDAY_SEP;
                end
                PH_D0:
                begin
                    if (is_dig)
                    begin
                        day_next   = 7'(d * 4'd10);
                        phase_next = PH_D1;
                    end
                    else
                        err_next = ST_DAY_FMT;
                end
                PH_D1:
                begin
                    if (is_dig)
                    begin
                        day_next   = day_reg + 7'(d);
                        phase_next = PH_DSEP;
                    end
                    else
                        err_next = ST_DAY_FMT;
                end
                PH_DSEP:
                begin
                    if (c == "-" || c == " ")
                    begin
                        phase_next = PH_MON;
                        off_next   = 4'd0;
                    end
                    else
                        err_next = ST_DAY_FMT;
                end
                PH_MON:
                begin
                    if (!m_found)
                        err_next = ST_MONTH;
                    else
                    begin
                        mpick_next = m_sel;
                        off_next   = off_reg + 4'd1;
                        if (off_reg == 4'd2)
                            phase_next = PH_MSEP;
                    end
                end
                PH_MSEP:
                begin
                    if (c == "-" || c == " ")
                        phase_next = PH_Y0;
                    else
                        err_next = ST_MONTH_SEP;
                end
                PH_Y0:
                begin
                    if (is_dig)
                    begin
                        two_next   = 7'(d);
                        phase_next = PH_Y1;
                    end
                    else
                        err_next = ST_YEAR;
                end
                PH_Y1:
                begin
                    if (is_dig)
                    begin
                        two_next   = 7'(two_reg * 7'd10) + 7'(d);
                        phase_next = PH_Y2;
                    end
                    else
                        err_next = ST_YEAR;
                end
                PH_Y2:
                begin
                    if (is_dig)
                    begin
                        d3_next    = d;
                        phase_next = PH_Y3;
                    end
                    else
                    begin
                        year_next = s_take.year;
                        if (s_take.err != ST_OK)
                            err_next = s_take.err;
                        else if (c == " ")
                        begin
                            phase_next = PH_TIME;
                            off_next   = 4'd0;
                        end
                        else
                            err_next = ST_YEAR_SEP;
                    end
                end
                PH_Y3:
                begin
                    if (is_dig)
                    begin
                        s_take     = settle(two_reg, 7'(d3_reg * 4'd10) + 7'(d),
                                            day_reg, mpick_reg);
                        year_next  = s_take.year;
                        err_next   = s_take.err;
                        phase_next = PH_YSEP;
                    end
                    else
                    begin
                        year_next = s_take.year;
                        err_next  = (s_take.err != ST_OK) ? s_take.err : ST_YEAR_SEP;
                    end
                end
                PH_YSEP:
                begin
                    if (c == " ")
                    begin
                        phase_next = PH_TIME;
                        off_next   = 4'd0;
                    end
                    else
                        err_next = ST_YEAR_SEP;
                end
                PH_TIME:
                begin
                    if (off_reg == 4'd2 || off_reg == 4'd5)
                    begin
                        if (c != ":")
                            err_next = ST_TIME_FMT;
                        else
                            off_next = off_reg + 4'd1;
                    end
                    else if (off_reg == 4'd8)
                    begin
                        if (c != " ")
                            err_next = ST_TIME_FMT;
                        else if (hour_reg >= 7'd24 || min_reg >= 7'd60 || sec_reg >= 7'd60)
                            err_next = ST_TIME_RANGE;
                        else
                        begin
                            phase_next = PH_ZONE;
                            off_next   = 4'd0;
                        end
                    end
                    else if (!is_dig)
                        err_next = ST_TIME_FMT;
                    else
                    begin
                        if (off_reg < 4'd2)
                            hour_next = 7'(hour_reg * 7'd10) + 7'(d);
                        else if (off_reg < 4'd5)
                            min_next = 7'(min_reg * 7'd10) + 7'(d);
                        else
                            sec_next = 7'(sec_reg * 7'd10) + 7'(d);
                        off_next = off_reg + 4'd1;
                    end
                end
                PH_ZONE:
                begin
                    if (off_reg > 4'd2
                        || lc != ((off_reg == 4'd0) ? "g" : (off_reg == 4'd1) ? "m" : "t"))
                        err_next = ST_ZONE;
                    else
                    begin
                        off_next = off_reg + 4'd1;
                        if (off_reg == 4'd2)
                            phase_next = PH_END;
                    end
                end
                default:
                    err_next = ST_ZONE;
            endcase
        end
    end

    // A string that ends early reports the field that was still expected.
    always_comb
    begin
        s_fin   = settle(widen_hi(two_next, year_pivot), two_next, day_next, mpick_next);
        fin_err = err_next;
        if (err_next == ST_OK)
        begin
            case (phase_next)
                PH_WDAY:  fin_err = ST_WEEKDAY;
                PH_WFULL: fin_err = ST_WDAY_SEP;
                PH_WSP:   fin_err = ST_WDAY_SEP;
                PH_D0:    fin_err = ST_DAY_FMT;
                PH_D1:    fin_err = ST_DAY_FMT;
                PH_DSEP:  fin_err = ST_DAY_FMT;
                PH_MON:   fin_err = ST_MONTH;
                PH_MSEP:  fin_err = ST_MONTH_SEP;
                PH_Y0:    fin_err = ST_YEAR;
                PH_Y1:    fin_err = ST_YEAR;
                PH_Y2:    fin_err = (s_fin.err != ST_OK) ? s_fin.err : ST_YEAR_SEP;
                PH_Y3:    fin_err = (s_fin.err != ST_OK) ? s_fin.err : ST_YEAR_SEP;
                PH_YSEP:  fin_err = ST_YEAR_SEP;
                PH_TIME:  fin_err = ST_TIME_FMT;
                PH_ZONE:  fin_err = ST_ZONE;
                default:  fin_err = ST_OK;
            endcase
        end
    end

    assign year_off_full       = year_next - 14'd1970;
    assign push_valid          = accept && date.last_char;
    assign push_entry.status   = fin_err;
    assign push_entry.year_off = year_off_full[7:0];
    assign push_entry.month    = mpick_next;
    assign push_entry.day      = day_next[4:0];
    assign push_entry.hour     = hour_next[4:0];
    assign push_entry.minute   = min_next[5:0];
    assign push_entry.second   = sec_next[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WDAY;
            wpick_reg <= '0;
            off_reg   <= '0;
            day_reg   <= '0;
            mpick_reg <= '0;
            two_reg   <= '0;
            d3_reg    <= '0;
            year_reg  <= '0;
            hour_reg  <= '0;
            min_reg   <= '0;
            sec_reg   <= '0;
            err_reg   <= ST_OK;
        end
        else if (accept)
        begin
            if (date.last_char)
            begin
                phase_reg <= PH_WDAY;
                wpick_reg <= '0;
                off_reg   <= '0;
                day_reg   <= '0;
                mpick_reg <= '0;
                two_reg   <= '0;
                d3_reg    <= '0;
                year_reg  <= '0;
                hour_reg  <= '0;
                min_reg   <= '0;
                sec_reg   <= '0;
                err_reg   <= ST_OK;
            end
            else
            begin
                phase_reg <= phase_next;
                wpick_reg <= wpick_next;
                off_reg   <= off_next;
                day_reg   <= day_next;
                mpick_reg <= mpick_next;
                two_reg   <= two_next;
                d3_reg    <= d3_next;
                year_reg  <= year_next;
                hour_reg  <= hour_next;
                min_reg   <= min_next;
                sec_reg   <= sec_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// ===== rtl/hdep_queue.sv =====
// Small FIFO of parsed date entries between the parser and the epoch stage.
// Depends on hdep_pkg.
module hdep_queue import hdep_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    input  entry_t push_entry,
    output logic   push_ready,
    output logic   pop_valid,
    output entry_t pop_entry,
    input  logic   pop_ready
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    entry_t              mem [QDEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [$clog2(QDEPTH+1)-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != ($clog2(QDEPTH+1))'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + {{($clog2(QDEPTH+1)-1){1'b0}}, do_push}
                               - {{($clog2(QDEPTH+1)-1){1'b0}}, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/hdep_back.sv =====
// Epoch stage: turns a parsed date into seconds in two registered steps.
// Depends on hdep_pkg and hdep_ifs.
module hdep_back import hdep_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pop_valid,
    input  entry_t       pop_entry,
    output logic         pop_ready,
    hdep_epoch_if.source epoch
);

    logic        a_valid_reg;
    logic [3:0]  a_status_reg;
    logic [16:0] a_days_reg, a_days_next;
    logic [16:0] a_tod_reg, a_tod_next;
    logic        o_valid_reg;
    logic [31:0] o_secs_reg, o_secs_next;
    logic [3:0]  o_status_reg;
    logic        en_out, en_a;
    logic [7:0]  yo;
    logic [6:0]  leaps;
    logic        leap_y;

    assign en_out    = !o_valid_reg || epoch.ready;
    assign en_a      = !a_valid_reg || en_out;
    assign pop_ready = en_a;

    // Leap years 1972..2104 follow the four-year rule except 2100 (offset 130).
    always_comb
    begin
        yo     = pop_entry.year_off;
        leaps  = 7'((9'(yo) + 9'd1) >> 2) - ((yo > 8'd130) ? 7'd1 : 7'd0);
        leap_y = (yo[1:0] == 2'd2) && (yo != 8'd130);
        a_days_next = 17'(yo * 9'd365) + 17'(leaps) + 17'(month_start(pop_entry.month))
                    + ((pop_entry.month >= 4'd2 && leap_y) ? 17'd1 : 17'd0)
                    + 17'(pop_entry.day) - 17'd1;
        a_tod_next  = 17'(pop_entry.hour * 12'd3600) + 17'(pop_entry.minute * 6'd60)
                    + 17'(pop_entry.second);
        o_secs_next = (a_status_reg != ST_OK) ? 32'hFFFF_FFFF
                    : 32'(a_days_reg * 17'd86400) + 32'(a_tod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_status_reg <= pop_entry.status;
            a_days_reg   <= a_days_next;
            a_tod_reg    <= a_tod_next;
        end
        if (en_out)
        begin
            o_secs_reg   <= o_secs_next;
            o_status_reg <= a_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_valid_reg <= pop_valid;
            if (en_out)
                o_valid_reg <= a_valid_reg;
        end
    end

    assign epoch.valid         = o_valid_reg;
    assign epoch.epoch_seconds = o_secs_reg;
    assign epoch.status        = o_status_reg;

endmodule

// ===== rtl/http_date_to_epoch_parser_unit.sv =====
// HTTP date parser top level: parser, result queue and epoch stage.
// Depends on hdep_pkg, hdep_ifs, hdep_front, hdep_queue and hdep_back.
//
// This block reads an HTTP date string such as "Sun, 25 Jan 2002 12:24:36 GMT"
// one byte per item on date_chan, with last_char marking the final byte, and
// returns one item on epoch_chan per string: the seconds since 1970-01-01 UTC
// and a status code, where any nonzero status carries an epoch of all ones.
// The parser takes one byte every cycle; it stalls only when the two-entry
// result queue is full, which happens when the result side holds back ready.
// After its last byte is accepted, the parsed entry lands in the queue at the
// accepting edge; the day count and time of day are then registered, and the
// multiply by 86400 fills the output register that offers the result. The year
// pivot is to be written through cfg_wr_en and cfg_wr_data only while no string
// is in flight, which the block itself does not enforce; it resets to 68.
module http_date_to_epoch_parser_unit import hdep_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    hdep_date_if.sink    date_chan,
    hdep_epoch_if.source epoch_chan,
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data
);

    logic [6:0] year_pivot_reg;
    logic       push_valid, push_ready;
    entry_t     push_entry;
    logic       pop_valid, pop_ready;
    entry_t     pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            year_pivot_reg <= PIVOT_RESET;
        else if (cfg_wr_en)
            year_pivot_reg <= cfg_wr_data;
    end

    hdep_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .date       (date_chan),
        .year_pivot (year_pivot_reg),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    hdep_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    hdep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .epoch     (epoch_chan)
    );

endmodule

// ===== rtl/hdep_checker.sv =====
// Port-level checks on the result channel of the HTTP date parser.
// Depends on hdep_pkg; bound to http_date_to_epoch_parser_unit.
module hdep_checker import hdep_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_epoch,
    input logic [3:0]  out_status
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Any failure carries an epoch of all ones.
    a_err_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_OK |-> out_epoch == 32'hFFFF_FFFF)
        else $error("error status with a real epoch");

    // Status codes stop at the year range code.
    a_status_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status <= ST_YEAR_RANGE)
        else $error("status code out of range");

endmodule

bind http_date_to_epoch_parser_unit hdep_checker u_hdep_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (epoch_chan.valid),
    .out_ready  (epoch_chan.ready),
    .out_epoch  (epoch_chan.epoch_seconds),
    .out_status (epoch_chan.status)
);
